[src/sdt_pkg.sv]
// sleep deadline table package: request/result types, carry and push structs,
// operation and status codes shared by the cell and the top level. No dependencies.
package sdt_pkg;

    localparam int DEF_ENTRIES        = 8;
    localparam int DEF_THREAD_ID_BITS = 6;
    localparam int TID_MAX_W          = 16;

    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_ARMED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_WOKEN     = 3'd3;
    localparam logic [2:0] ST_NONE_DUE  = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  thread_id;
        logic [31:0] delay_ticks;
        logic [31:0] now_tick;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] entry_index;
        logic [5:0] woken_thread;
        logic [3:0] freed_count;
        logic       last;
    } t_out_item;

    // request as seen by every cell while it travels down the chain
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_tick;
        logic [31:0] deadline;
    } t_req;

    // running state handed from cell to cell
    typedef struct packed {
        logic       claimed;
        logic       hold_valid;
        logic [2:0] idx;
        logic [5:0] thread;
        logic [3:0] freed;
    } t_carry;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_push;

endpackage

[src/sdt_cell.sv]
// sleep deadline table cell: one table entry (busy, owner, deadline) plus the
// token and carry registers of the scan chain. Depends on sdt_pkg.
module sdt_cell
    import sdt_pkg::*;
#(
    parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS,
    parameter int CELL_INDEX     = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_tok,
    input  t_carry                    i_carry,
    input  t_req                      i_req,
    input  logic [THREAD_ID_BITS-1:0] i_tid,
    output logic                      o_tok,
    output t_carry                    o_carry,
    output t_push                     o_push
);

    localparam logic [2:0] IDX = 3'(CELL_INDEX);

    logic                      r_busy;
    logic                      n_busy;
    logic [THREAD_ID_BITS-1:0] r_owner;
    logic [31:0]               r_deadline;
    logic                      r_tok;
    t_carry                    r_carry;
    t_carry                    n_carry;
    logic                      write;
    logic [31:0]               diff;
    logic                      due;
    logic [TID_MAX_W-1:0]      owner_ext;

    assign diff      = i_req.now_tick - r_deadline;
    assign due       = r_busy && !diff[31];
    assign owner_ext = TID_MAX_W'(r_owner);

    always_comb begin
        n_carry = i_carry;
        n_busy  = r_busy;
        write   = 1'b0;
        o_push  = '0;
        if (i_tok) begin
            unique case (i_req.op)
                OP_ARM: begin
                    if (!r_busy && !i_carry.claimed) begin
                        n_busy          = 1'b1;
                        write           = 1'b1;
                        n_carry.claimed = 1'b1;
                        n_carry.idx     = IDX;
                    end
                end
                OP_CANCEL: begin
                    if (r_busy && (r_owner == i_tid)) begin
                        n_busy        = 1'b0;
                        n_carry.freed = i_carry.freed + 4'd1;
                    end
                end
                OP_TICK: begin
                    if (due) begin
                        n_busy = 1'b0;
                        // a newer wake releases the one held back, which is not the last
                        if (i_carry.hold_valid) begin
                            o_push.valid             = 1'b1;
                            o_push.item.status       = ST_WOKEN;
                            o_push.item.entry_index  = i_carry.idx;
                            o_push.item.woken_thread = i_carry.thread;
                        end
                        n_carry.hold_valid = 1'b1;
                        n_carry.idx        = IDX;
                        n_carry.thread     = owner_ext[5:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tok  <= 1'b0;
        end else if (i_en) begin
            r_busy <= n_busy;
            r_tok  <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_carry <= n_carry;
            if (write) begin
                r_owner    <= i_tid;
                r_deadline <= i_req.deadline;
            end
        end
    end

    assign o_tok   = r_tok;
    assign o_carry = r_carry;

endmodule

[src/sleep_deadline_table.sv]
// sleep deadline table top level: request/result handshakes, request register,
// the chain of sdt_cell entries and the result register. Depends on sdt_pkg, sdt_cell.
//
// Usage: a request (op, thread_id, delay_ticks, now_tick) is taken on i_in_valid and
// o_in_ready. Arm claims the lowest free entry with deadline now + max(delay, 1);
// cancel frees every entry of a thread and gives the count; tick frees every entry
// whose deadline has passed (signed wrap-safe compare) and gives one result per
// woken entry in entry order, last set on the final one, or one nothing-due result.
// Op 3 is taken and gives no result; o_in_ready stays high after it.
// A request walks the cell chain one entry per cycle while the output is not stalled;
// its final result shows on o_out_valid once the token leaves the last cell; only
// one request is in flight and o_in_ready is low while it walks, so the next request
// is taken only after the previous one has left the chain.
// Results sit in one output register; when the receiver holds i_out_ready low the
// whole chain freezes until the register is taken, and nothing is dropped.
// Reset (synchronous, active low) frees every entry and empties the chain and the
// output register.
module sleep_deadline_table
    import sdt_pkg::*;
#(
    parameter int ENTRIES        = DEF_ENTRIES,
    parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic                      r_scan;
    logic                      r_start;
    t_req                      r_req;
    logic [THREAD_ID_BITS-1:0] r_tid;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic                      en;
    logic                      accept;
    logic [TID_MAX_W-1:0]      tid_ext;
    logic [31:0]               delay_eff;
    logic                      tok   [ENTRIES+1];
    t_carry                    carry [ENTRIES+1];
    t_push                     push  [ENTRIES];
    logic [ENTRIES-1:0]        tok_vec;
    t_push                     cell_push;
    t_push                     final_push;
    t_push                     out_push;
    t_carry                    fin;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_scan;
    assign accept     = i_in_valid && o_in_ready;
    assign tid_ext    = TID_MAX_W'(i_in.thread_id);
    assign delay_eff  = (i_in.delay_ticks == 32'd0) ? 32'd1 : i_in.delay_ticks;

    assign tok[0]   = r_start;
    assign carry[0] = '0;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        sdt_cell #(
            .THREAD_ID_BITS (THREAD_ID_BITS),
            .CELL_INDEX     (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tok   (tok[k]),
            .i_carry (carry[k]),
            .i_req   (r_req),
            .i_tid   (r_tid),
            .o_tok   (tok[k+1]),
            .o_carry (carry[k+1]),
            .o_push  (push[k])
        );
        assign tok_vec[k] = tok[k+1];
    end

    // only the cell holding the token can push
    always_comb begin
        cell_push = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            cell_push = cell_push | push[k];
        end
    end

    // closing result once the token leaves the last cell
    assign fin = carry[ENTRIES];
    always_comb begin
        final_push            = '0;
        final_push.valid      = tok[ENTRIES];
        final_push.item.last  = 1'b1;
        unique case (r_req.op)
            OP_ARM: begin
                if (fin.claimed) begin
                    final_push.item.status      = ST_ARMED;
                    final_push.item.entry_index = fin.idx;
                end else begin
                    final_push.item.status = ST_FULL;
                end
            end
            OP_CANCEL: begin
                final_push.item.status      = ST_CANCELLED;
                final_push.item.freed_count = fin.freed;
            end
            OP_TICK: begin
                if (fin.hold_valid) begin
                    final_push.item.status       = ST_WOKEN;
                    final_push.item.entry_index  = fin.idx;
                    final_push.item.woken_thread = fin.thread;
                end else begin
                    final_push.item.status = ST_NONE_DUE;
                end
            end
            default: final_push.valid = 1'b0;
        endcase
    end

    assign out_push = cell_push.valid ? cell_push : final_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && (i_in.op != OP_NONE)) begin
                r_scan  <= 1'b1;
                r_start <= 1'b1;
            end else begin
                if (en) begin
                    r_start <= 1'b0;
                end
                if (en && tok[ENTRIES]) begin
                    r_scan <= 1'b0;
                end
            end
            if (en) begin
                r_out_valid <= out_push.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op       <= i_in.op;
            r_req.now_tick <= i_in.now_tick;
            r_req.deadline <= i_in.now_tick + delay_eff;
            r_tid          <= tid_ext[THREAD_ID_BITS-1:0];
        end
        if (en) begin
            r_out <= out_push.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_one_token : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_start, tok_vec}))
        else $error("more than one request token in the chain");

    a_idle_no_token : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_scan |-> ({r_start, tok_vec} == '0))
        else $error("token in the chain while no request is in flight");

    a_single_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[ENTRIES] |-> !cell_push.valid)
        else $error("cell result and closing result in the same cycle");

    a_frozen_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && !accept) |=> $stable({r_start, tok_vec}))
        else $error("chain moved while the result register was stalled");
`endif

endmodule
